// ===== hdl/fara_pkg.sv =====
// ----------------------------------------------------------------------------
// fara_pkg
// Shared types for the fraction add and reduce core: sequencer and GCD states,
// and the status word that the iterative units report back to the sequencer.
// ----------------------------------------------------------------------------
package fara_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_GSTART,
		ST_GWAIT,
		ST_DNSTART,
		ST_DNWAIT,
		ST_DDSTART,
		ST_DDWAIT,
		ST_DONE
	} fara_state_t;

	typedef enum logic [1:0] {
		G_IDLE,
		G_RUN,
		G_SCALE
	} gcd_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// ===== hdl/fara_mul.sv =====
// ----------------------------------------------------------------------------
// fara_mul
// Shared unsigned multiplier with a registered product. The sequencer feeds
// it one operand pair per cycle.
// ----------------------------------------------------------------------------
module fara_mul #(
	parameter int W = 16
) (
	input  logic             clk,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [2*W-1:0]   p
);

	logic [2*W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (2*W)'(a) * (2*W)'(b);
	end

	assign p = p_q;

endmodule

// ===== hdl/fara_gcd.sv =====
// ----------------------------------------------------------------------------
// fara_gcd
// Binary GCD of two magnitudes, one shift or subtract per cycle. Gives 1
// when either operand is zero. Result holds until the next start.
// ----------------------------------------------------------------------------
module fara_gcd
	import fara_pkg::*;
#(
	parameter int M = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [M-1:0]  p_in,
	input  logic [M-1:0]  q_in,
	output logic [M-1:0]  g,
	output unit_sts_t     sts
);

	localparam int KW = (M > 2) ? $clog2(M) : 1;

	gcd_state_t    state_q;
	logic [M-1:0]  p_q;
	logic [M-1:0]  q_q;
	logic [KW-1:0] k_q;
	logic          done_q;
	logic [M:0]    diff;

	// single subtractor; the borrow bit doubles as the compare
	assign diff = {1'b0, p_q} - {1'b0, q_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				G_IDLE: begin
					if (start) state_q <= (p_in == '0 || q_in == '0) ? G_SCALE : G_RUN;
				end
				G_RUN: begin
					if (diff == '0) state_q <= G_SCALE;
				end
				G_SCALE: begin
					if (k_q == '0) begin
						state_q <= G_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				if (start) begin
					k_q <= '0;
					if (p_in == '0 || q_in == '0) begin
						p_q <= M'(1);
						q_q <= M'(1);
					end else begin
						p_q <= p_in;
						q_q <= q_in;
					end
				end
			end
			G_RUN: begin
				if (diff != '0) begin
					if (!p_q[0] && !q_q[0]) begin
						p_q <= p_q >> 1;
						q_q <= q_q >> 1;
						k_q <= k_q + KW'(1);
					end else if (!p_q[0]) begin
						p_q <= p_q >> 1;
					end else if (!q_q[0]) begin
						q_q <= q_q >> 1;
					end else if (!diff[M]) begin
						p_q <= diff[M-1:0] >> 1;
					end else begin
						q_q <= (~diff[M-1:0] + M'(1)) >> 1;
					end
				end
			end
			G_SCALE: begin
				// restore the common power of two
				if (k_q != '0) begin
					p_q <= p_q << 1;
					k_q <= k_q - KW'(1);
				end
			end
			default: ;
		endcase
	end

	assign g        = p_q;
	assign sts.busy = (state_q != G_IDLE);
	assign sts.done = done_q;

endmodule

// ===== hdl/fara_div.sv =====
// ----------------------------------------------------------------------------
// fara_div
// Restoring divider, one quotient bit per cycle.
// Used for both exact divisions by the common divisor.
// ----------------------------------------------------------------------------
module fara_div
	import fara_pkg::*;
#(
	parameter int M = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [M-1:0]  dividend,
	input  logic [M-1:0]  divisor,
	output logic [M-1:0]  quotient,
	output unit_sts_t     sts
);

	localparam int CW = $clog2(M + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [M-1:0]  rem_q;
	logic [M-1:0]  quo_q;
	logic [M-1:0]  dvs_q;
	logic [M:0]    trial;
	logic [M+1:0]  diff;

	assign trial = {rem_q, quo_q[M-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(M - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				dvs_q <= divisor;
			end
		end else if (!diff[M+1]) begin
			rem_q <= diff[M-1:0];
			quo_q <= {quo_q[M-2:0], 1'b1};
		end else begin
			rem_q <= trial[M-1:0];
			quo_q <= {quo_q[M-2:0], 1'b0};
		end
	end

	assign quotient = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// ===== hdl/fraction_add_and_reduce_core.sv =====
// ----------------------------------------------------------------------------
// fraction_add_and_reduce_core
// Reduces a signed fraction, or adds two by cross multiplication and reduces
// the sum, using a shared multiplier, a binary GCD unit and a serial divider.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | operation, num_a, den_a, num_b, den_b
//  out     | out_valid / out_stall| result_num, result_den
//
//  One item at a time; in_stall stays high from acceptance until the result
//  has been written to the output register.
//  Reset clears the sequencer, unit control and the output valid only.
//  A held output does not block the next input beat; only a second result
//  waits in the final state while out_stall is high.
// ----------------------------------------------------------------------------
module fraction_add_and_reduce_core
	import fara_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic signed [OPERAND_WIDTH-1:0]   num_a,
	input  logic signed [OPERAND_WIDTH-1:0]   den_a,
	input  logic signed [OPERAND_WIDTH-1:0]   num_b,
	input  logic signed [OPERAND_WIDTH-1:0]   den_b,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [2*OPERAND_WIDTH:0]   result_num,
	output logic signed [2*OPERAND_WIDTH-1:0] result_den
);

	localparam int W  = OPERAND_WIDTH;
	localparam int M  = 2 * W;
	localparam int RN = M + 1;

	fara_state_t state_q, state_d;

	logic [W-1:0] na_mag, da_mag, nb_mag, db_mag;
	logic [W-1:0] na_mag_q, da_mag_q, nb_mag_q, db_mag_q;
	logic [1:0]   mcnt_q;
	logic [M-1:0] t1_q, t2_q;
	logic         t1_neg_q, t2_neg_q;
	logic [M-1:0] num_mag_q, den_mag_q;
	logic         num_neg_q, den_neg_q;
	logic [M-1:0] g_q, qn_q, qd_q;

	logic [W-1:0] mul_a, mul_b;
	logic [M-1:0] prod;
	logic         t1n, t2n;
	logic [M:0]   add_diff;
	logic [M-1:0] sum_mag;
	logic         sum_neg;

	logic [M-1:0] gcd_g;
	unit_sts_t    gcd_sts;
	logic         gcd_start;

	logic [M-1:0] div_dividend, div_quo;
	unit_sts_t    div_sts;
	logic         div_start;

	logic          out_valid_q;
	logic [RN-1:0] res_num_q;
	logic [M-1:0]  res_den_q;
	logic          out_load;
	logic [RN-1:0] num_ext;

	// magnitudes of the incoming operands
	assign na_mag = num_a[W-1] ? (~num_a + W'(1)) : num_a;
	assign da_mag = den_a[W-1] ? (~den_a + W'(1)) : den_a;
	assign nb_mag = num_b[W-1] ? (~num_b + W'(1)) : num_b;
	assign db_mag = den_b[W-1] ? (~den_b + W'(1)) : den_b;

	// operand pairs: na*db, nb*da, da*db
	always_comb begin
		case (mcnt_q)
			2'd0:    begin mul_a = na_mag_q; mul_b = db_mag_q; end
			2'd1:    begin mul_a = nb_mag_q; mul_b = da_mag_q; end
			default: begin mul_a = da_mag_q; mul_b = db_mag_q; end
		endcase
	end

	fara_mul #(.W(W)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// sign-magnitude add of the two cross products
	assign t1n      = t1_neg_q && (t1_q != '0);
	assign t2n      = t2_neg_q && (t2_q != '0);
	assign add_diff = {1'b0, t1_q} - {1'b0, t2_q};

	always_comb begin
		if (t1n == t2n) begin
			sum_mag = t1_q + t2_q;
			sum_neg = t1n;
		end else if (!add_diff[M]) begin
			sum_mag = add_diff[M-1:0];
			sum_neg = t1n;
		end else begin
			sum_mag = ~add_diff[M-1:0] + M'(1);
			sum_neg = t2n;
		end
	end

	assign gcd_start = (state_q == ST_GSTART);

	fara_gcd #(.M(M)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.p_in   (num_mag_q),
		.q_in   (den_mag_q),
		.g      (gcd_g),
		.sts    (gcd_sts)
	);

	assign div_start    = (state_q == ST_DNSTART) || (state_q == ST_DDSTART);
	assign div_dividend = (state_q == ST_DNSTART) ? num_mag_q : den_mag_q;

	fara_div #(.M(M)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (g_q),
		.quotient (div_quo),
		.sts      (div_sts)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = operation ? ST_MUL : ST_GSTART;
			end
			ST_MUL: begin
				if (mcnt_q == 2'd3) state_d = ST_ADD;
			end
			ST_ADD:     state_d = ST_GSTART;
			ST_GSTART:  state_d = ST_GWAIT;
			ST_GWAIT: begin
				if (gcd_sts.done) state_d = ST_DNSTART;
			end
			ST_DNSTART: state_d = ST_DNWAIT;
			ST_DNWAIT: begin
				if (div_sts.done) state_d = ST_DDSTART;
			end
			ST_DDSTART: state_d = ST_DDWAIT;
			ST_DDWAIT: begin
				if (div_sts.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					na_mag_q  <= na_mag;
					da_mag_q  <= da_mag;
					nb_mag_q  <= nb_mag;
					db_mag_q  <= db_mag;
					mcnt_q    <= 2'd0;
					t1_neg_q  <= num_a[W-1] ^ den_b[W-1];
					t2_neg_q  <= num_b[W-1] ^ den_a[W-1];
					num_mag_q <= M'(na_mag);
					num_neg_q <= num_a[W-1];
					den_mag_q <= M'(da_mag);
					den_neg_q <= operation ? (den_a[W-1] ^ den_b[W-1]) : den_a[W-1];
				end
			end
			ST_MUL: begin
				mcnt_q <= mcnt_q + 2'd1;
				case (mcnt_q)
					2'd1:    t1_q      <= prod;
					2'd2:    t2_q      <= prod;
					2'd3:    den_mag_q <= prod;
					default: ;
				endcase
			end
			ST_ADD: begin
				num_mag_q <= sum_mag;
				num_neg_q <= sum_neg;
			end
			ST_GWAIT: begin
				if (gcd_sts.done) g_q <= gcd_g;
			end
			ST_DNWAIT: begin
				if (div_sts.done) qn_q <= div_quo;
			end
			ST_DDWAIT: begin
				if (div_sts.done) qd_q <= div_quo;
			end
			default: ;
		endcase
	end

	// output register
	assign num_ext = RN'(qn_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_num_q <= (num_neg_q && qn_q != '0) ? (~num_ext + RN'(1)) : num_ext;
			res_den_q <= (den_neg_q && qd_q != '0) ? (~qd_q + M'(1)) : qd_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign result_num = res_num_q;
	assign result_den = res_den_q;

`ifndef SYNTH
	a_gcd_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_sts.done |-> state_q == ST_GWAIT)
		else $error("gcd finished outside its wait state");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DNWAIT || state_q == ST_DDWAIT))
		else $error("divider finished outside a wait state");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_sts.done |-> gcd_g != '0)
		else $error("gcd returned zero");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q != ST_IDLE)
		else $error("accepted beat did not start the sequencer");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fraction_add_and_reduce_core. Fractions are reduced,
// or summed and then reduced. Results are predicted in wide integer arithmetic
// when each input beat is accepted, and every output beat is checked in order.
// Directed corner fractions come first, then about a thousand random ones.
// The sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W     = 16;
	localparam int LIMIT = 1_500_000;
	localparam int DRAIN = 400;
	localparam int N_RND = 1126;

	typedef enum logic {
		OP_REDUCE = 1'b0,
		OP_ADD    = 1'b1
	} frac_op_t;

	typedef struct {
		frac_op_t             op;
		logic signed [W-1:0]  na;
		logic signed [W-1:0]  da;
		logic signed [W-1:0]  nb;
		logic signed [W-1:0]  db;
	} frac_item_t;

	typedef struct {
		logic signed [2*W:0]   num;
		logic signed [2*W-1:0] den;
	} frac_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  operation = 1'b0;
	logic signed [W-1:0]   num_a = '0;
	logic signed [W-1:0]   den_a = '0;
	logic signed [W-1:0]   num_b = '0;
	logic signed [W-1:0]   den_b = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [2*W:0]   result_num;
	logic signed [2*W-1:0] result_den;

	frac_item_t   stim_items[$];
	frac_result_t expected_results[$];
	frac_item_t   bus_item;
	frac_result_t want;
	frac_result_t got_want;

	int cycles = 0;
	int mismatches = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int reduce_count = 0;
	int add_count = 0;
	int zero_part_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	fraction_add_and_reduce_core #(
		.OPERAND_WIDTH(W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.num_a(num_a),
		.den_a(den_a),
		.num_b(num_b),
		.den_b(den_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_num(result_num),
		.result_den(result_den)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Euclid on magnitudes; a zero part leaves the fraction as it is
	function automatic longint unsigned common_factor(longint unsigned p, longint unsigned q);
		longint unsigned t;
		if (p == 0 || q == 0)
			return 1;
		while (q != 0) begin
			t = p % q;
			p = q;
			q = t;
		end
		return p;
	endfunction

	function automatic frac_result_t reduce_fraction(frac_item_t it);
		longint          n;
		longint          d;
		longint unsigned g;
		frac_result_t    r;
		if (it.op == OP_ADD) begin
			n = longint'(it.na) * longint'(it.db) + longint'(it.nb) * longint'(it.da);
			d = longint'(it.da) * longint'(it.db);
		end else begin
			n = longint'(it.na);
			d = longint'(it.da);
		end
		g = common_factor((n < 0) ? -n : n, (d < 0) ? -d : d);
		n = n / longint'(g);
		d = d / longint'(g);
		r.num = n[2*W:0];
		r.den = d[2*W-1:0];
		return r;
	endfunction

	task automatic push_item(frac_op_t op, int na, int da, int nb, int db);
		frac_item_t it;
		it.op = op;
		it.na = na[W-1:0];
		it.da = da[W-1:0];
		it.nb = nb[W-1:0];
		it.db = db[W-1:0];
		stim_items.push_back(it);
	endtask

	// mix of full-range values, small values, extremes and values with common factors
	function automatic int rand_operand();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
			4, 5:       v = int'($urandom_range(0, 40)) - 20;
			6: begin
				case ($urandom_range(0, 4))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					3: v = 1;
					default: v = -1;
				endcase
			end
			default: begin
				v = int'($urandom_range(1, 64)) * int'($urandom_range(1, 500));
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// sender: bursts of beats separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = reduce_fraction(bus_item);
				expected_results.push_back(want);
				beats_sent++;
				if (bus_item.op == OP_ADD)
					add_count++;
				else
					reduce_count++;
				if (want.num == 0 || want.den == 0)
					zero_part_count++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (stim_items.size() > 0) begin
					bus_item = stim_items.pop_front();
					in_valid  <= 1'b1;
					operation <= bus_item.op;
					num_a     <= bus_item.na;
					den_a     <= bus_item.da;
					num_b     <= bus_item.nb;
					den_b     <= bus_item.db;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						case ($urandom_range(0, 3))
							0, 3: gap_left = 0;
							1:    gap_left = $urandom_range(1, 5);
							default: gap_left = $urandom_range(5, 160);
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: the stall pattern is redrawn at random intervals
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(10, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 1);
			2: out_stall <= ($urandom_range(0, 7) != 0);
			default: out_stall <= ((cycles % 48) < 20);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result beat with none expected: num %0d den %0d", result_num, result_den);
				mismatches++;
			end else begin
				got_want = expected_results.pop_front();
				beats_checked++;
				if (result_num !== got_want.num) begin
					$error("result_num expected %0d actual %0d", got_want.num, result_num);
					mismatches++;
				end
				if (result_den !== got_want.den) begin
					$error("result_den expected %0d actual %0d", got_want.den, result_den);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_results.size());
			$display("fraction_add_and_reduce_core: mismatch");
			$finish;
		end
	end

	initial begin
		// signs in every corner
		push_item(OP_REDUCE, 6, 4, 0, 0);
		push_item(OP_REDUCE, -6, 4, 0, 0);
		push_item(OP_REDUCE, 6, -4, 0, 0);
		push_item(OP_REDUCE, -6, -4, 0, 0);
		// zero parts pass through
		push_item(OP_REDUCE, 0, 5, 0, 0);
		push_item(OP_REDUCE, 5, 0, 0, 0);
		push_item(OP_REDUCE, 0, 0, 0, 0);
		// extremes of the operand range
		push_item(OP_REDUCE, -32768, -32768, 0, 0);
		push_item(OP_REDUCE, 32767, -32768, 0, 0);
		push_item(OP_REDUCE, -32768, 1, 0, 0);
		push_item(OP_REDUCE, 32767, 32767, 0, 0);
		push_item(OP_REDUCE, -32768, 16384, 0, 0);
		// second operand must not matter when reducing
		push_item(OP_REDUCE, 12, 18, -32768, 32767);
		push_item(OP_REDUCE, 12, 18, 32767, -32768);
		push_item(OP_ADD, 1, 2, 1, 3);
		push_item(OP_ADD, 1, 2, -1, 2);
		push_item(OP_ADD, -1, -2, 1, 2);
		push_item(OP_ADD, -32768, 1, -32768, 1);
		push_item(OP_ADD, -32768, 32767, -32768, 32767);
		push_item(OP_ADD, 32767, -32768, -32768, 32767);
		push_item(OP_ADD, -32768, -32768, -32768, -32768);
		push_item(OP_ADD, 1, 0, 1, 2);
		push_item(OP_ADD, 3, 4, 5, 0);
		push_item(OP_ADD, 0, 7, 0, -9);
		push_item(OP_ADD, 32767, 1, 32767, 1);

		for (int i = 0; i < N_RND; i++) begin
			frac_item_t it;
			int da;
			da = rand_operand();
			it.op = ($urandom_range(0, 9) < 4) ? OP_REDUCE : OP_ADD;
			it.na = W'(rand_operand());
			it.da = da[W-1:0];
			it.nb = W'(rand_operand());
			// shared denominators make the sum reduce further
			if ($urandom_range(0, 4) == 0)
				it.db = it.da;
			else
				it.db = W'(rand_operand());
			stim_items.push_back(it);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d beats sent (%0d reductions, %0d sums), %0d results checked",
			beats_sent, reduce_count, add_count, beats_checked);
		$display("%0d results had a zero part, %0d field mismatches", zero_part_count,
			mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("fraction_add_and_reduce_core: match");
		end else begin
			$display("fraction_add_and_reduce_core: mismatch");
		end
		$finish;
	end

endmodule

// ===== fraction_add_and_reduce_core.f =====
hdl/fara_pkg.sv
hdl/fara_mul.sv
hdl/fara_gcd.sv
hdl/fara_div.sv
hdl/fraction_add_and_reduce_core.sv
tb/sv/testbench.sv
